### sv/sgw_pkg.sv
package sgw_pkg;

  // build-time defaults
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned MAX_SEGMENTS = 32;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned PHYS_W   = 48;
  localparam int unsigned SEGLEN_W = 33;
  localparam int unsigned BYTES_W  = 32;
  localparam int unsigned OFS_W    = 40;
  localparam int unsigned ADDR_W   = 49;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SUM_W    = OFS_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PUSH  = 2'd1,
    OP_WALK  = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_SEARCH,
    S_OFFSET,
    S_AVAIL,
    S_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    STEP_SEARCH,
    STEP_OFFSET,
    STEP_AVAIL,
    STEP_EMIT
  } step_op_e;

  typedef struct packed {
    step_op_e            op;
    logic [OFS_W-1:0]    start;
    logic [OFS_W-1:0]    offset;
    logic [BYTES_W-1:0]  bytes;
    logic [BYTES_W-1:0]  inseg;
    logic [OFS_W-1:0]    rem;
    logic [BYTES_W-1:0]  avail;
    logic                first;
    logic [PHYS_W-1:0]   base;
    logic [OFS_W-1:0]    done;
  } step_in_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic                hit;
    logic [BYTES_W-1:0]  take;
    logic [OFS_W-1:0]    rem_n;
    logic [ADDR_W-1:0]   addr;
    logic [OFS_W-1:0]    done_n;
  } step_out_t;

endpackage

### sv/sgw_if.sv
interface sgw_in_if;
  logic                         valid;
  logic                         ready;
  logic [sgw_pkg::OP_W-1:0]     opcode;
  logic [sgw_pkg::PHYS_W-1:0]   seg_phys_addr;
  logic [sgw_pkg::SEGLEN_W-1:0] seg_length;
  logic [sgw_pkg::OFS_W-1:0]    walk_offset;
  logic [sgw_pkg::OFS_W-1:0]    walk_count;
  logic [sgw_pkg::OFS_W-1:0]    buffer_length;

  modport source (
    output valid, opcode, seg_phys_addr, seg_length, walk_offset, walk_count,
           buffer_length,
    input  ready
  );
  modport sink (
    input  valid, opcode, seg_phys_addr, seg_length, walk_offset, walk_count,
           buffer_length,
    output ready
  );
endinterface

interface sgw_out_if;
  logic                         valid;
  logic                         ready;
  logic [sgw_pkg::ADDR_W-1:0]   chunk_addr;
  logic [sgw_pkg::BYTES_W-1:0]  chunk_len;
  logic                         last;
  logic [sgw_pkg::OFS_W-1:0]    total_done;
  logic [sgw_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, chunk_addr, chunk_len, last, total_done, status,
    input  ready
  );
  modport sink (
    input  valid, chunk_addr, chunk_len, last, total_done, status,
    output ready
  );
endinterface

### sv/sgw_seg_mem.sv
module sgw_seg_mem #(
  parameter int unsigned DEPTH      = sgw_pkg::MAX_SEGMENTS,
  parameter int unsigned IDX_W      = 5,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [IDX_W-1:0]            wr_idx_i,
  input  logic [sgw_pkg::PHYS_W-1:0]  wr_phys_i,
  input  logic [sgw_pkg::BYTES_W-1:0] wr_bytes_i,
  input  logic [IDX_W-1:0]            rd_idx_i,
  output logic [sgw_pkg::PHYS_W-1:0]  rd_base_o,
  output logic [sgw_pkg::BYTES_W-1:0] rd_bytes_o
);

  localparam int unsigned FRAME_W = sgw_pkg::PHYS_W - PAGE_SHIFT;

  logic [FRAME_W-1:0]          seg_frame       [DEPTH];
  logic [PAGE_SHIFT-1:0]       seg_page_offset [DEPTH];
  logic [sgw_pkg::BYTES_W-1:0] seg_bytes       [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      seg_frame[wr_idx_i]       <= wr_phys_i[sgw_pkg::PHYS_W-1:PAGE_SHIFT];
      seg_page_offset[wr_idx_i] <= wr_phys_i[PAGE_SHIFT-1:0];
      seg_bytes[wr_idx_i]       <= wr_bytes_i;
    end
  end

  // frame base plus page offset rebuilt on read
  always_ff @(posedge clk_i) begin
    rd_base_o  <= {seg_frame[rd_idx_i], seg_page_offset[rd_idx_i]};
    rd_bytes_o <= seg_bytes[rd_idx_i];
  end

endmodule

### sv/sgw_step_unit.sv
module sgw_step_unit (
  input  sgw_pkg::step_in_t  step_i,
  output sgw_pkg::step_out_t step_o
);

  logic [sgw_pkg::SUM_W-1:0]   opa;
  logic [sgw_pkg::SUM_W-1:0]   opb;
  logic                        sub;
  logic [sgw_pkg::SUM_W-1:0]   sum;
  logic [sgw_pkg::BYTES_W-1:0] avail_sel;
  logic                        short;

  always_comb begin
    avail_sel = step_i.first ? step_i.avail : step_i.bytes;
    opa = '0;
    opb = '0;
    sub = 1'b0;
    unique case (step_i.op)
      sgw_pkg::STEP_SEARCH: begin
        opa = sgw_pkg::SUM_W'(step_i.start);
        opb = sgw_pkg::SUM_W'(step_i.bytes);
      end
      sgw_pkg::STEP_OFFSET: begin
        opa = sgw_pkg::SUM_W'(step_i.offset);
        opb = sgw_pkg::SUM_W'(step_i.start);
        sub = 1'b1;
      end
      sgw_pkg::STEP_AVAIL: begin
        opa = sgw_pkg::SUM_W'(step_i.bytes);
        opb = sgw_pkg::SUM_W'(step_i.inseg);
        sub = 1'b1;
      end
      sgw_pkg::STEP_EMIT: begin
        opa = sgw_pkg::SUM_W'(step_i.rem);
        opb = sgw_pkg::SUM_W'(avail_sel);
        sub = 1'b1;
      end
    endcase
  end

  // one shared add/subtract, sign bit is the borrow
  assign sum   = opa + (opb ^ {sgw_pkg::SUM_W{sub}}) + sgw_pkg::SUM_W'(sub);
  assign short = sum[sgw_pkg::SUM_W-1];

  always_comb begin
    step_o.sum    = sum;
    step_o.hit    = sum > sgw_pkg::SUM_W'(step_i.offset);
    step_o.take   = short ? step_i.rem[sgw_pkg::BYTES_W-1:0] : avail_sel;
    step_o.rem_n  = short ? '0 : sum[sgw_pkg::OFS_W-1:0];
    step_o.addr   = sgw_pkg::ADDR_W'(step_i.base) + sgw_pkg::ADDR_W'(step_i.inseg);
    step_o.done_n = step_i.done + sgw_pkg::OFS_W'(step_o.take);
  end

endmodule

### sv/scatter_gather_segment_walker_top.sv
// Scatter-gather segment walker. Requests arrive on req_i and results leave
// on rsp_o, both valid/ready. Opcode clear empties the segment table, push
// appends one segment (status too_big for a length above 32 bits, full when
// the table holds MAX_SEGMENTS entries), and walk turns a logical offset and
// byte count, clamped to the list total and the buffer length, into one
// physical chunk per segment touched; the last chunk carries the byte count
// walked, and a walk that covers nothing gives one zero-length last result.
// Each request gives its results in order, and one request is in flight at a
// time: req_i.ready is high only while the sequencer is idle. Clear and push
// answer from the response state. A walk searches past the segments before
// the start segment, finds the offset inside it and the bytes left in it,
// then emits the chunks, and output stalls can hold it. The single step unit
// handles one segment per cycle while the output is not stalled, and the
// segment store's one registered read port is read ahead at the next index.
// The store needs no clearing after reset; entries at or above the segment
// count are never used.
module scatter_gather_segment_walker_top #(
  parameter int unsigned PAGE_BYTES   = sgw_pkg::PAGE_BYTES,
  parameter int unsigned MAX_SEGMENTS = sgw_pkg::MAX_SEGMENTS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sgw_in_if.sink    req_i,
  sgw_out_if.source rsp_o
);

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned IDX_W      = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned TOT_W      = sgw_pkg::BYTES_W + $clog2(MAX_SEGMENTS);
  localparam int unsigned OFS_W      = sgw_pkg::OFS_W;
  localparam int unsigned BYTES_W    = sgw_pkg::BYTES_W;

  // sequencer state
  sgw_pkg::seq_state_e state_q, state_d;
  logic [CNT_W-1:0]    i_q, i_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [TOT_W-1:0]    total_q, total_d;
  sgw_pkg::status_e    status_q, status_d;

  // walk working registers
  logic [OFS_W-1:0]    offset_q, offset_d;
  logic [OFS_W-1:0]    rem_q, rem_d;
  logic [OFS_W-1:0]    start_q, start_d;
  logic [OFS_W-1:0]    done_q, done_d;
  logic [BYTES_W-1:0]  inseg_q, inseg_d;
  logic [BYTES_W-1:0]  avail_q, avail_d;
  logic                first_q, first_d;

  // output register
  logic                         ovalid_q, ovalid_d;
  logic [sgw_pkg::ADDR_W-1:0]   oaddr_q, oaddr_d;
  logic [BYTES_W-1:0]           olen_q, olen_d;
  logic                         olast_q, olast_d;
  logic [OFS_W-1:0]             odone_q, odone_d;
  logic [sgw_pkg::STATUS_W-1:0] ostatus_q, ostatus_d;

  // segment store
  logic                       mem_we;
  logic [sgw_pkg::PHYS_W-1:0] rd_base;
  logic [BYTES_W-1:0]         rd_bytes;

  sgw_pkg::step_in_t  step_in;
  sgw_pkg::step_out_t step_out;

  logic             slot_free;
  logic [CNT_W-1:0] i_inc;
  logic [OFS_W-1:0] total_ext;
  logic             c_le_t, c_le_b, t_le_b;
  logic [OFS_W-1:0] walk_size;
  logic             emit_last;

  sgw_seg_mem #(
    .DEPTH      (MAX_SEGMENTS),
    .IDX_W      (IDX_W),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_mem (
    .clk_i      (clk_i),
    .wr_en_i    (mem_we),
    .wr_idx_i   (cnt_q[IDX_W-1:0]),
    .wr_phys_i  (req_i.seg_phys_addr),
    .wr_bytes_i (req_i.seg_length[BYTES_W-1:0]),
    .rd_idx_i   (i_d[IDX_W-1:0]),
    .rd_base_o  (rd_base),
    .rd_bytes_o (rd_bytes)
  );

  sgw_step_unit u_step (
    .step_i (step_in),
    .step_o (step_out)
  );

  assign req_i.ready = (state_q == sgw_pkg::S_IDLE);
  assign slot_free   = !ovalid_q || rsp_o.ready;
  assign i_inc       = i_q + CNT_W'(1);
  assign total_ext   = OFS_W'(total_q);

  // clamp of the walk to list total and buffer length, compares in parallel
  assign c_le_t = req_i.walk_count <= total_ext;
  assign c_le_b = req_i.walk_count <= req_i.buffer_length;
  assign t_le_b = total_ext <= req_i.buffer_length;

  always_comb begin
    if (c_le_t && c_le_b) begin
      walk_size = req_i.walk_count;
    end else if (!c_le_t && t_le_b) begin
      walk_size = total_ext;
    end else begin
      walk_size = req_i.buffer_length;
    end
  end

  // chunk is last when the count runs out or the table ends
  assign emit_last = (step_out.rem_n == '0) || (i_inc == cnt_q);

  function automatic logic [CNT_W-1:0] i_inc_cnt(input logic [CNT_W-1:0] v);
    i_inc_cnt = v + CNT_W'(1);
  endfunction

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    status_d  = status_q;
    offset_d  = offset_q;
    rem_d     = rem_q;
    start_d   = start_q;
    done_d    = done_q;
    inseg_d   = inseg_q;
    avail_d   = avail_q;
    first_d   = first_q;
    ovalid_d  = ovalid_q && !rsp_o.ready;
    oaddr_d   = oaddr_q;
    olen_d    = olen_q;
    olast_d   = olast_q;
    odone_d   = odone_q;
    ostatus_d = ostatus_q;
    mem_we    = 1'b0;

    step_in.op     = sgw_pkg::STEP_SEARCH;
    step_in.start  = start_q;
    step_in.offset = offset_q;
    step_in.bytes  = rd_bytes;
    step_in.inseg  = inseg_q;
    step_in.rem    = rem_q;
    step_in.avail  = avail_q;
    step_in.first  = first_q;
    step_in.base   = rd_base;
    step_in.done   = done_q;

    unique case (state_q)
      sgw_pkg::S_IDLE: begin
        // keep entry 0 ready in the read register
        i_d = '0;
        if (req_i.valid) begin
          unique case (sgw_pkg::opcode_e'(req_i.opcode))
            sgw_pkg::OP_CLEAR: begin
              cnt_d    = '0;
              total_d  = '0;
              status_d = sgw_pkg::ST_OK;
              state_d  = sgw_pkg::S_RESP;
            end
            sgw_pkg::OP_PUSH: begin
              if (req_i.seg_length[sgw_pkg::SEGLEN_W-1]) begin
                status_d = sgw_pkg::ST_TOO_BIG;
              end else if (cnt_q == CNT_W'(MAX_SEGMENTS)) begin
                status_d = sgw_pkg::ST_FULL;
              end else begin
                status_d = sgw_pkg::ST_OK;
                mem_we   = 1'b1;
                cnt_d    = i_inc_cnt(cnt_q);
                total_d  = total_q + TOT_W'(req_i.seg_length[BYTES_W-1:0]);
              end
              state_d = sgw_pkg::S_RESP;
            end
            sgw_pkg::OP_WALK: begin
              offset_d = req_i.walk_offset;
              rem_d    = walk_size;
              start_d  = '0;
              done_d   = '0;
              state_d  = sgw_pkg::S_SEARCH;
            end
            default: begin
              // unused opcode: no effect, no result
            end
          endcase
        end
      end

      sgw_pkg::S_RESP: begin
        if (slot_free) begin
          ovalid_d  = 1'b1;
          oaddr_d   = '0;
          olen_d    = '0;
          olast_d   = 1'b1;
          odone_d   = '0;
          ostatus_d = status_q;
          state_d   = sgw_pkg::S_IDLE;
        end
      end

      sgw_pkg::S_SEARCH: begin
        step_in.op = sgw_pkg::STEP_SEARCH;
        if ((rem_q == '0) || (i_q == cnt_q)) begin
          // nothing to walk
          status_d = sgw_pkg::ST_OK;
          state_d  = sgw_pkg::S_RESP;
        end else if (step_out.hit) begin
          state_d = sgw_pkg::S_OFFSET;
        end else begin
          start_d = step_out.sum[OFS_W-1:0];
          i_d     = i_inc;
        end
      end

      sgw_pkg::S_OFFSET: begin
        // offset inside the start segment
        step_in.op = sgw_pkg::STEP_OFFSET;
        inseg_d    = step_out.sum[BYTES_W-1:0];
        state_d    = sgw_pkg::S_AVAIL;
      end

      sgw_pkg::S_AVAIL: begin
        // bytes left in the start segment
        step_in.op = sgw_pkg::STEP_AVAIL;
        avail_d    = step_out.sum[BYTES_W-1:0];
        first_d    = 1'b1;
        state_d    = sgw_pkg::S_EMIT;
      end

      sgw_pkg::S_EMIT: begin
        step_in.op = sgw_pkg::STEP_EMIT;
        if (slot_free) begin
          ovalid_d  = 1'b1;
          oaddr_d   = step_out.addr;
          olen_d    = step_out.take;
          olast_d   = emit_last;
          odone_d   = emit_last ? step_out.done_n : '0;
          ostatus_d = sgw_pkg::ST_OK;
          rem_d     = step_out.rem_n;
          done_d    = step_out.done_n;
          inseg_d   = '0;
          first_d   = 1'b0;
          i_d       = i_inc;
          if (emit_last) begin
            state_d = sgw_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_d = sgw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sgw_pkg::S_IDLE;
      cnt_q    <= '0;
      total_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      total_q  <= total_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    status_q  <= status_d;
    offset_q  <= offset_d;
    rem_q     <= rem_d;
    start_q   <= start_d;
    done_q    <= done_d;
    inseg_q   <= inseg_d;
    avail_q   <= avail_d;
    first_q   <= first_d;
    oaddr_q   <= oaddr_d;
    olen_q    <= olen_d;
    olast_q   <= olast_d;
    odone_q   <= odone_d;
    ostatus_q <= ostatus_d;
  end

  assign rsp_o.valid      = ovalid_q;
  assign rsp_o.chunk_addr = oaddr_q;
  assign rsp_o.chunk_len  = olen_q;
  assign rsp_o.last       = olast_q;
  assign rsp_o.total_done = odone_q;
  assign rsp_o.status     = ostatus_q;

`ifndef SYNTHESIS
  // table never grows past its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count above table depth");

  // chunks are only cut from segments that exist
  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgw_pkg::S_EMIT) |-> (i_q < cnt_q))
    else $error("chunk emitted past the end of the table");

  // a walk ends only on a chunk marked last
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgw_pkg::S_EMIT && state_d == sgw_pkg::S_IDLE) |=>
      (ovalid_q && olast_q))
    else $error("walk finished without a last chunk");
`endif

endmodule

### verif/scatter_gather_segment_walker_top_tb.sv
`timescale 1ns / 100ps

module scatter_gather_segment_walker_top_tb;

  import sgw_pkg::*;

  // page split of a physical address as the segment table keeps it
  localparam int unsigned PG_W    = $clog2(PAGE_BYTES);
  localparam int unsigned FRAME_W = PHYS_W - PG_W;

  // opcode 3 is left unused by the block
  localparam logic [OP_W-1:0]     OP_RESERVED  = 2'd3;
  localparam logic [SEGLEN_W-1:0] SEG_LEN_MAX  = {1'b0, {BYTES_W{1'b1}}};
  localparam logic [SEGLEN_W-1:0] SEG_LEN_OVER = {1'b1, {BYTES_W{1'b0}}};
  localparam logic [OFS_W-1:0]    OFS_ALL_ONES = {OFS_W{1'b1}};

  localparam int unsigned TAIL_CYCLES     = 2 * MAX_SEGMENTS + 16;
  localparam int unsigned DRAIN_LIMIT     = 200000;
  localparam int unsigned RSP_HOLD_CYCLES = 400;
  localparam int unsigned REQ_BUDGET      = 370;
  localparam int unsigned TAIL_REQS       = 70;

  typedef struct {
    logic [OP_W-1:0]     opcode;
    logic [PHYS_W-1:0]   phys;
    logic [SEGLEN_W-1:0] seg_len;
    logic [OFS_W-1:0]    ofs;
    logic [OFS_W-1:0]    cnt;
    logic [OFS_W-1:0]    buf_len;
  } sg_request_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] len;
    logic               last;
    logic [OFS_W-1:0]   done;
    status_e            status;
  } chunk_desc_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sgw_in_if  req_if ();
  sgw_out_if rsp_if ();

  scatter_gather_segment_walker_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the segment table, updated when a request is accepted
  logic [FRAME_W-1:0] tbl_frame [MAX_SEGMENTS];
  logic [PG_W-1:0]    tbl_pofs  [MAX_SEGMENTS];
  logic [BYTES_W-1:0] tbl_bytes [MAX_SEGMENTS];
  int unsigned        tbl_count = 0;
  logic [SUM_W-1:0]   tbl_total = '0;

  // chunk descriptors still owed by the block, oldest first
  chunk_desc_t chunk_q [$];

  bit          idle_en = 1'b1;
  int unsigned rsp_hold_cycles = 0;
  int unsigned err_count = 0;

  // run statistics for the summary
  int unsigned reqs_sent = 0;
  int unsigned n_clears = 0;
  int unsigned n_reserved = 0;
  int unsigned n_walks = 0;
  int unsigned n_empty_walks = 0;
  int unsigned max_chunks = 0;
  int unsigned n_push_ok = 0;
  int unsigned n_push_too_big = 0;
  int unsigned n_push_full = 0;
  int unsigned results_seen = 0;
  int unsigned held_offer_cycles = 0;

  // ---------------------------------------------------------------------------
  // table model: applies one accepted request and queues the chunks it owes
  // ---------------------------------------------------------------------------
  function automatic void predict_chunks(sg_request_t r);
    chunk_desc_t        d;
    logic [SUM_W-1:0]   size;
    logic [SUM_W-1:0]   seg_start;
    logic [SUM_W-1:0]   remaining;
    logic [SUM_W-1:0]   avail;
    logic [SUM_W-1:0]   take;
    logic [SUM_W-1:0]   gap;
    logic [SUM_W-1:0]   covered;
    logic [BYTES_W-1:0] inseg;
    int unsigned        i;
    int unsigned        n;
    d.addr   = '0;
    d.len    = '0;
    d.last   = 1'b1;
    d.done   = '0;
    d.status = ST_OK;
    case (r.opcode)
      OP_CLEAR: begin
        tbl_count = 0;
        tbl_total = '0;
        n_clears++;
        chunk_q.push_back(d);
      end
      OP_PUSH: begin
        // too_big outranks full; neither touches the table
        if (r.seg_len > SEG_LEN_MAX) begin
          d.status = ST_TOO_BIG;
          n_push_too_big++;
        end else if (tbl_count >= MAX_SEGMENTS) begin
          d.status = ST_FULL;
          n_push_full++;
        end else begin
          tbl_frame[tbl_count] = r.phys[PHYS_W-1:PG_W];
          tbl_pofs[tbl_count]  = r.phys[PG_W-1:0];
          tbl_bytes[tbl_count] = r.seg_len[BYTES_W-1:0];
          tbl_count++;
          tbl_total = tbl_total + r.seg_len;
          n_push_ok++;
        end
        chunk_q.push_back(d);
      end
      OP_WALK: begin
        n_walks++;
        // clamp to the list total, then to the caller buffer
        size = r.cnt;
        if (size > tbl_total) size = tbl_total;
        if (r.buf_len < size) size = r.buf_len;
        // start segment: first one whose end lies past the offset
        i = 0;
        seg_start = '0;
        while (i < tbl_count && seg_start + tbl_bytes[i] <= r.ofs) begin
          seg_start = seg_start + tbl_bytes[i];
          i++;
        end
        gap = r.ofs - seg_start;
        inseg = (i < tbl_count) ? gap[BYTES_W-1:0] : '0;
        remaining = size;
        n = 0;
        // one chunk per segment touched, zero-length segments included
        while (remaining != 0 && i < tbl_count) begin
          avail = tbl_bytes[i] - inseg;
          take = (remaining < avail) ? remaining : avail;
          remaining = remaining - take;
          covered = size - remaining;
          d.addr = {tbl_frame[i], tbl_pofs[i]} + inseg;
          d.len  = take[BYTES_W-1:0];
          d.last = (remaining == 0) || (i + 1 == tbl_count);
          d.done = d.last ? covered[OFS_W-1:0] : '0;
          chunk_q.push_back(d);
          inseg = '0;
          i++;
          n++;
        end
        // nothing walked: one zero-length last descriptor (d still at defaults)
        if (n == 0) begin
          chunk_q.push_back(d);
          n_empty_walks++;
        end
        if (n > max_chunks) max_chunks = n;
      end
      default: begin
        n_reserved++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] random_word64();
    return {$urandom(), $urandom()};
  endfunction

  // uniform-ish value in [0, lim]
  function automatic logic [SUM_W-1:0] rand_upto(logic [SUM_W-1:0] lim);
    logic [63:0] w;
    logic [63:0] span;
    w = random_word64();
    span = 64'(lim) + 64'd1;
    w = w % span;
    return w[SUM_W-1:0];
  endfunction

  // every field random; callers overwrite the ones the opcode uses
  function automatic sg_request_t noise_request(logic [OP_W-1:0] op);
    sg_request_t r;
    logic [63:0] w;
    r.opcode = op;
    w = random_word64();
    r.phys = w[PHYS_W-1:0];
    w = random_word64();
    r.seg_len = w[SEGLEN_W-1:0];
    w = random_word64();
    r.ofs = w[OFS_W-1:0];
    w = random_word64();
    r.cnt = w[OFS_W-1:0];
    w = random_word64();
    r.buf_len = w[OFS_W-1:0];
    return r;
  endfunction

  function automatic logic [PHYS_W-1:0] pick_phys();
    logic [63:0] w;
    w = random_word64();
    if ($urandom_range(0, 3) == 0) w[PG_W-1:0] = '0;
    return w[PHYS_W-1:0];
  endfunction

  // mostly short segments, some full 32-bit ones, a few over the limit
  function automatic logic [SEGLEN_W-1:0] pick_seg_len();
    int unsigned         pick;
    logic [SEGLEN_W-1:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 10) len = '0;
    else if (pick < 50) len = SEGLEN_W'($urandom_range(1, 64));
    else if (pick < 70) len = SEGLEN_W'($urandom_range(65, 3 * PAGE_BYTES));
    else if (pick < 88) len = {1'b0, $urandom()};
    else if (pick < 94) len = SEG_LEN_MAX;
    else len = {1'b1, $urandom()};
    return len;
  endfunction

  // offsets mostly inside the list or on a segment boundary, else anywhere
  function automatic sg_request_t pick_walk();
    sg_request_t      r;
    logic [SUM_W-1:0] pos;
    logic [SUM_W-1:0] room;
    int unsigned      pick;
    int unsigned      k;
    int unsigned      j;
    r = noise_request(OP_WALK);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      pos = rand_upto(tbl_total);
      r.ofs = pos[OFS_W-1:0];
    end else if (pick < 80 && tbl_count != 0) begin
      k = $urandom_range(0, tbl_count - 1);
      pos = '0;
      for (j = 0; j < k; j++) pos = pos + tbl_bytes[j];
      r.ofs = pos[OFS_W-1:0];
    end
    room = (r.ofs <= tbl_total) ? tbl_total - r.ofs : '0;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      pos = rand_upto(room + 8);
      r.cnt = pos[OFS_W-1:0];
    end else if (pick < 65) begin
      r.cnt = OFS_ALL_ONES;
    end else if (pick < 80) begin
      r.cnt = OFS_W'($urandom_range(0, 8));
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      r.buf_len = OFS_ALL_ONES;  // fill case
    end else if (pick < 90) begin
      pos = rand_upto({1'b0, r.cnt});
      r.buf_len = pos[OFS_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(sg_request_t r);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.opcode        <= r.opcode;
    req_if.seg_phys_addr <= r.phys;
    req_if.seg_length    <= r.seg_len;
    req_if.walk_offset   <= r.ofs;
    req_if.walk_count    <= r.cnt;
    req_if.buffer_length <= r.buf_len;
    do begin
      @(posedge clk_i);
      if (!req_if.ready && rsp_hold_cycles != 0) held_offer_cycles++;
    end while (!req_if.ready);
    predict_chunks(r);
    if (r.opcode != OP_RESERVED) reqs_sent++;
  endtask

  task automatic send_op(logic [OP_W-1:0] op);
    send_request(noise_request(op));
  endtask

  task automatic send_push(logic [PHYS_W-1:0] phys, logic [SEGLEN_W-1:0] len);
    sg_request_t r;
    r = noise_request(OP_PUSH);
    r.phys = phys;
    r.seg_len = len;
    send_request(r);
  endtask

  task automatic send_walk(logic [OFS_W-1:0] ofs, logic [OFS_W-1:0] cnt,
                           logic [OFS_W-1:0] buf_len);
    sg_request_t r;
    r = noise_request(OP_WALK);
    r.ofs = ofs;
    r.cnt = cnt;
    r.buf_len = buf_len;
    send_request(r);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus a long hold when a test asks for one
  // ---------------------------------------------------------------------------
  initial begin : rsp_ready_drive
    int unsigned stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold_cycles != 0) begin
        rsp_hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  function automatic void compare_field(string name, logic [63:0] want,
                                        logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // every accepted result is matched against the oldest owed descriptor
  initial begin : rsp_check
    chunk_desc_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        results_seen++;
        if (chunk_q.size() == 0) begin
          $error("unexpected result: chunk_addr 0x%0h chunk_len 0x%0h last %0b",
                 rsp_if.chunk_addr, rsp_if.chunk_len, rsp_if.last);
          err_count++;
        end else begin
          want = chunk_q.pop_front();
          compare_field("chunk_addr", 64'(want.addr), 64'(rsp_if.chunk_addr));
          compare_field("chunk_len", 64'(want.len), 64'(rsp_if.chunk_len));
          compare_field("last", 64'(want.last), 64'(rsp_if.last));
          compare_field("total_done", 64'(want.done), 64'(rsp_if.total_done));
          compare_field("status", 64'(want.status), 64'(rsp_if.status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // straight out of reset the table is empty
  task automatic test_empty_table();
    send_walk('0, OFS_ALL_ONES, OFS_ALL_ONES);
    send_op(OP_CLEAR);
  endtask

  // table ends up as lengths 0, 2^32-1, 100, 0, 50
  task automatic test_push_extremes();
    send_push('0, '0);
    send_push({PHYS_W{1'b1}}, SEG_LEN_MAX);
    send_push(48'h0012_3456_7FFF, 33'd100);
    send_push(48'h0ABC_DEF0_1000, '0);
    send_push(48'h8000_0000_0800, 33'd50);
    send_push(pick_phys(), SEG_LEN_OVER);
    send_push(pick_phys(), {SEGLEN_W{1'b1}});
  endtask

  task automatic test_walk_edges();
    logic [SUM_W-1:0] last_byte;
    last_byte = tbl_total - 1;
    // whole list: leading empty segment skipped, middle one gives a 0 chunk
    send_walk('0, OFS_ALL_ONES, OFS_ALL_ONES);
    // exactly one segment, stops without touching the next
    send_walk(40'h00_FFFF_FFFF, 40'd100, OFS_ALL_ONES);
    // straddles the empty segment
    send_walk(40'h01_0000_0062, 40'd2, OFS_ALL_ONES);
    // nothing to walk: zero count, zero buffer, offset at and past the end
    send_walk(40'd10, '0, OFS_ALL_ONES);
    send_walk(40'd10, OFS_ALL_ONES, '0);
    send_walk(tbl_total[OFS_W-1:0], OFS_ALL_ONES, OFS_ALL_ONES);
    send_walk(OFS_ALL_ONES, OFS_ALL_ONES, OFS_ALL_ONES);
    // final byte of the list
    send_walk(last_byte[OFS_W-1:0], 40'd1, OFS_ALL_ONES);
    // buffer limits the walk
    send_walk('0, OFS_ALL_ONES, 40'd5);
    // count clamped to the total, walk runs off the end of the table
    send_walk(40'd5, 40'h02_0000_0000, OFS_ALL_ONES);
  endtask

  task automatic test_unused_opcode();
    sg_request_t r;
    send_op(OP_RESERVED);
    r.opcode  = OP_RESERVED;
    r.phys    = {PHYS_W{1'b1}};
    r.seg_len = {SEGLEN_W{1'b1}};
    r.ofs     = OFS_ALL_ONES;
    r.cnt     = OFS_ALL_ONES;
    r.buf_len = OFS_ALL_ONES;
    send_request(r);
    send_op(OP_CLEAR);
    send_walk('0, OFS_ALL_ONES, OFS_ALL_ONES);
  endtask

  task automatic test_table_full();
    logic [SUM_W-1:0] pos;
    send_op(OP_CLEAR);
    repeat (MAX_SEGMENTS) send_push(pick_phys(), SEGLEN_W'($urandom_range(1, 300)));
    send_push(pick_phys(), 33'd5);
    // too_big takes priority over full
    send_push(pick_phys(), SEG_LEN_OVER);
    // one chunk per table entry
    send_walk('0, OFS_ALL_ONES, OFS_ALL_ONES);
    pos = rand_upto(tbl_total);
    send_walk(pos[OFS_W-1:0], OFS_ALL_ONES, OFS_ALL_ONES);
  endtask

  // well-formed lists of random content with a little noise mixed in
  task automatic run_list_sequence();
    int unsigned n_segs;
    int unsigned n_walk_reqs;
    if ($urandom_range(0, 3) != 0) send_op(OP_CLEAR);
    if ($urandom_range(0, 9) == 0) n_segs = $urandom_range(20, MAX_SEGMENTS + 3);
    else n_segs = $urandom_range(0, 6);
    repeat (n_segs) send_push(pick_phys(), pick_seg_len());
    n_walk_reqs = $urandom_range(1, 5);
    repeat (n_walk_reqs) begin
      if ($urandom_range(0, 19) == 0) send_op(OP_RESERVED);
      else if ($urandom_range(0, 19) == 0) send_push(pick_phys(), pick_seg_len());
      send_request(pick_walk());
    end
  endtask

  task automatic test_random_lists();
    while (reqs_sent < REQ_BUDGET - TAIL_REQS) run_list_sequence();
  endtask

  // results are held back for a long stretch while requests keep coming,
  // so the block stays busy and has to stall its request input
  task automatic test_output_backpressure();
    rsp_hold_cycles = RSP_HOLD_CYCLES;
    send_op(OP_CLEAR);
    repeat (8) send_push(pick_phys(), SEGLEN_W'($urandom_range(1, 256)));
    repeat (4) send_walk('0, OFS_ALL_ONES, OFS_ALL_ONES);
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_unthrottled_tail();
    idle_en = 1'b0;
    while (reqs_sent < REQ_BUDGET) run_list_sequence();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned guard;
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.opcode        <= OP_CLEAR;
    req_if.seg_phys_addr <= '0;
    req_if.seg_length    <= '0;
    req_if.walk_offset   <= '0;
    req_if.walk_count    <= '0;
    req_if.buffer_length <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_push_extremes();
    test_walk_edges();
    test_unused_opcode();
    test_table_full();
    test_random_lists();
    test_output_backpressure();
    test_unthrottled_tail();

    // drain, then give a stray late result time to show up
    req_if.valid <= 1'b0;
    guard = 0;
    while (chunk_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (chunk_q.size() != 0) begin
      $error("%0d expected results never arrived", chunk_q.size());
      err_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests: %0d clears, %0d pushes (%0d ok, %0d too_big, %0d full),",
             reqs_sent, n_clears, n_push_ok + n_push_too_big + n_push_full, n_push_ok,
             n_push_too_big, n_push_full);
    $display("%0d walks (%0d empty, max %0d chunks), %0d unused ops, %0d results, %0d stalls",
             n_walks, n_empty_walks, max_chunks, n_reserved, results_seen,
             held_offer_cycles);
    if (err_count == 0) begin
      $display("scatter_gather_segment_walker_top regression: pass");
    end else begin
      $display("scatter_gather_segment_walker_top regression: fail");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : run_limit
    #12_000_000;
    $display("scatter_gather_segment_walker_top regression: fail");
    $finish;
  end

endmodule
